// ----- rtl/core/tvsd_pkg.sv -----
// Tagged value stream decoder: shared types, token kinds, error codes and
// header field constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tvsd_pkg;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_HDR,
        PH_PAY,
        PH_STR,
        PH_PEND_END,
        PH_PEND_ERR
    } phase_t;

    typedef logic [3:0] kind_t;
    typedef logic [2:0] err_t;
    typedef logic [2:0] htype_t;
    typedef logic [4:0] cookie_t;

    localparam kind_t K_NIL    = 4'd0;
    localparam kind_t K_BOOL   = 4'd1;
    localparam kind_t K_INT    = 4'd2;
    localparam kind_t K_REAL   = 4'd3;
    localparam kind_t K_USER   = 4'd4;
    localparam kind_t K_FUNC   = 4'd5;
    localparam kind_t K_SSTART = 4'd6;
    localparam kind_t K_SBYTE  = 4'd7;
    localparam kind_t K_TABLE  = 4'd8;
    localparam kind_t K_END    = 4'd9;
    localparam kind_t K_ERR    = 4'd10;

    localparam err_t E_NONE      = 3'd0;
    localparam err_t E_INT_SIZE  = 3'd1;
    localparam err_t E_LSTR_SIZE = 3'd2;
    localparam err_t E_TRUNC     = 3'd3;
    localparam err_t E_COUNT     = 3'd4;

    localparam htype_t T_NIL    = 3'd0;
    localparam htype_t T_BOOL   = 3'd1;
    localparam htype_t T_NUMBER = 3'd2;
    localparam htype_t T_USER   = 3'd3;
    localparam htype_t T_SSTR   = 3'd4;
    localparam htype_t T_LSTR   = 3'd5;
    localparam htype_t T_TABLE  = 3'd6;
    localparam htype_t T_FUNC   = 3'd7;

    localparam int      COOKIE_SPAN  = 32;
    localparam cookie_t COOKIE_COUNT = cookie_t'(COOKIE_SPAN - 1);
    localparam cookie_t COOKIE_REAL  = 5'd8;
    localparam cookie_t COOKIE_QWORD = 5'd6;

    localparam logic [31:0] LEN_HDR_BYTES = 32'd4;

    // Payload size in bytes for an integer cookie, 0 for an invalid cookie.
    function automatic logic [3:0] int_size(input cookie_t c);
        logic [3:0] r;
        case (c)
            5'd1:         r = 4'd1;
            5'd2:         r = 4'd2;
            5'd4:         r = 4'd4;
            COOKIE_QWORD: r = 4'd8;
            default:      r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/tagged_value_stream_decoder_unit.sv -----
// Tagged value stream decoder top level: byte stream in, one token per value and per string byte out.
// Depends on tvsd_pkg.
// A token is registered: it appears in the cycle after the byte that completes it is accepted.
// Throughput: one byte per cycle; the input stalls only while a token is held unread.
// Reset (rst_n, async, active low): waiting for the 4-byte length header, no token held.
`timescale 1ns / 1ps
`default_nettype none

module tagged_value_stream_decoder_unit
    import tvsd_pkg::*;
#(
    parameter int POINTER_BYTES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [7:0]  data_byte,
    input  wire logic        data_valid,
    output logic             data_ready,
    output logic [3:0]       kind,
    output logic [63:0]      value,
    output logic [31:0]      length,
    output logic [2:0]       error_code,
    output logic             token_valid,
    input  wire logic        token_ready
);

    localparam logic [3:0] PTR_SIZE = 4'(POINTER_BYTES);

    phase_t      phase_reg, phase_next;
    logic [1:0]  hbc_reg, hbc_next;
    logic [31:0] remaining_reg, remaining_next;
    logic [63:0] shift_reg, shift_next;
    logic [3:0]  pay_left_reg, pay_left_next;
    logic [3:0]  pay_size_reg, pay_size_next;
    logic [31:0] str_left_reg, str_left_next;
    kind_t       pending_reg, pending_next;
    logic        ce_reg, ce_next;

    logic        tok_valid_reg, tok_valid_next;
    kind_t       kind_reg, kind_next;
    logic [63:0] value_reg, value_next;
    logic [31:0] length_reg, length_next;
    err_t        err_reg, err_next;

    logic        acc;
    htype_t      hdr_type;
    cookie_t     hdr_cookie;
    logic [3:0]  isize;
    logic        count_bad;
    logic [2:0]  lane;
    logic [63:0] shift_upd;
    logic [3:0]  pay_left_dec;
    logic        pay_done;
    logic [63:0] pay_v;
    logic [31:0] str_left_dec;
    logic [31:0] rem_dec;
    logic        rem_zero;
    logic [63:0] len_shift;
    logic [31:0] total;
    logic        total_ok;

    phase_t      step_phase;
    logic        step_ce;
    logic        raw_hit;
    kind_t       raw_kind;
    logic [63:0] raw_value;
    logic [31:0] raw_len;
    err_t        raw_err;
    logic        start_pay;
    kind_t       start_kind;
    logic [3:0]  start_size;
    logic        str_load;
    logic [31:0] str_load_val;
    logic        clean;

    assign acc          = data_valid && data_ready;
    assign data_ready   = !tok_valid_reg || token_ready;
    assign hdr_type     = data_byte[2:0];
    assign hdr_cookie   = data_byte[7:3];
    assign isize        = int_size(hdr_cookie);
    assign count_bad    = ce_reg && (hdr_type != T_NUMBER || hdr_cookie == COOKIE_REAL);
    assign lane         = 3'(pay_size_reg - pay_left_reg);
    assign shift_upd    = shift_reg | ({56'd0, data_byte} << {lane, 3'b000});
    assign pay_left_dec = pay_left_reg - 4'd1;
    assign pay_done     = (pay_left_dec == 4'd0);
    assign pay_v        = (pending_reg == K_INT && pay_size_reg == 4'd4 && shift_upd[31])
                          ? {32'hFFFF_FFFF, shift_upd[31:0]} : shift_upd;
    assign str_left_dec = str_left_reg - 32'd1;
    assign rem_dec      = (remaining_reg != 32'd0) ? remaining_reg - 32'd1 : remaining_reg;
    assign rem_zero     = (rem_dec == 32'd0);
    assign len_shift    = shift_reg | ({56'd0, data_byte} << {hbc_reg, 3'b000});
    assign total        = len_shift[31:0];
    assign total_ok     = (total > LEN_HDR_BYTES) && !total[31];
    assign clean        = (step_phase == PH_HDR) && !step_ce;

    // decode of one header, payload or string byte
    always_comb
    begin
        step_phase   = phase_reg;
        step_ce      = ce_reg;
        raw_hit      = 1'b0;
        raw_kind     = K_NIL;
        raw_value    = 64'd0;
        raw_len      = 32'd0;
        raw_err      = E_NONE;
        start_pay    = 1'b0;
        start_kind   = K_NIL;
        start_size   = 4'd0;
        str_load     = 1'b0;
        str_load_val = 32'd0;
        case (phase_reg)
            PH_HDR:
            begin
                step_ce = 1'b0;
                if (count_bad)
                begin
                    raw_hit  = 1'b1;
                    raw_kind = K_ERR;
                    raw_err  = E_COUNT;
                end
                else
                begin
                    case (hdr_type)
                        T_NIL:
                        begin
                            raw_hit  = 1'b1;
                            raw_kind = K_NIL;
                        end
                        T_BOOL:
                        begin
                            raw_hit   = 1'b1;
                            raw_kind  = K_BOOL;
                            raw_value = {63'd0, hdr_cookie != 5'd0};
                        end
                        T_NUMBER:
                        begin
                            if (hdr_cookie == 5'd0)
                            begin
                                raw_hit  = 1'b1;
                                raw_kind = K_INT;
                            end
                            else if (hdr_cookie == COOKIE_REAL)
                            begin
                                start_pay  = 1'b1;
                                start_kind = K_REAL;
                                start_size = 4'd8;
                            end
                            else if (isize != 4'd0)
                            begin
                                start_pay  = 1'b1;
                                start_kind = K_INT;
                                start_size = isize;
                            end
                            else
                            begin
                                raw_hit  = 1'b1;
                                raw_kind = K_ERR;
                                raw_err  = E_INT_SIZE;
                            end
                        end
                        T_USER:
                        begin
                            start_pay  = 1'b1;
                            start_kind = K_USER;
                            start_size = PTR_SIZE;
                        end
                        T_SSTR:
                        begin
                            raw_hit  = 1'b1;
                            raw_kind = K_SSTART;
                            raw_len  = {27'd0, hdr_cookie};
                            if (hdr_cookie != 5'd0)
                            begin
                                str_load     = 1'b1;
                                str_load_val = {27'd0, hdr_cookie};
                                step_phase   = PH_STR;
                            end
                        end
                        T_LSTR:
                        begin
                            if (hdr_cookie == 5'd2 || hdr_cookie == 5'd4)
                            begin
                                start_pay  = 1'b1;
                                start_kind = K_SSTART;
                                start_size = hdr_cookie[3:0];
                            end
                            else
                            begin
                                raw_hit  = 1'b1;
                                raw_kind = K_ERR;
                                raw_err  = E_LSTR_SIZE;
                            end
                        end
                        T_TABLE:
                        begin
                            raw_hit  = 1'b1;
                            raw_kind = K_TABLE;
                            raw_len  = {27'd0, hdr_cookie};
                            step_ce  = (hdr_cookie == COOKIE_COUNT);
                        end
                        default:
                        begin
                            start_pay  = 1'b1;
                            start_kind = K_FUNC;
                            start_size = PTR_SIZE;
                        end
                    endcase
                    if (start_pay)
                        step_phase = PH_PAY;
                end
            end
            PH_PAY:
            begin
                if (pay_done)
                begin
                    step_phase = PH_HDR;
                    raw_hit    = 1'b1;
                    if (pending_reg == K_SSTART)
                    begin
                        raw_kind     = K_SSTART;
                        raw_len      = shift_upd[31:0];
                        str_load     = 1'b1;
                        str_load_val = shift_upd[31:0];
                        if (shift_upd[31:0] != 32'd0)
                            step_phase = PH_STR;
                    end
                    else
                    begin
                        raw_kind  = pending_reg;
                        raw_value = pay_v;
                    end
                end
            end
            PH_STR:
            begin
                raw_hit    = 1'b1;
                raw_kind   = K_SBYTE;
                raw_value  = {56'd0, data_byte};
                step_phase = (str_left_dec == 32'd0) ? PH_HDR : PH_STR;
            end
            default:
            begin
            end
        endcase
    end

    // next state
    always_comb
    begin
        phase_next     = phase_reg;
        hbc_next       = hbc_reg;
        remaining_next = remaining_reg;
        shift_next     = shift_reg;
        pay_left_next  = pay_left_reg;
        pay_size_next  = pay_size_reg;
        str_left_next  = str_left_reg;
        pending_next   = pending_reg;
        ce_next        = ce_reg;
        if (acc)
        begin
            case (phase_reg)
                PH_PEND_END, PH_PEND_ERR:
                begin
                    phase_next = PH_LEN;
                    hbc_next   = 2'd1;
                    shift_next = {56'd0, data_byte};
                    ce_next    = 1'b0;
                end
                PH_LEN:
                begin
                    if (hbc_reg != 2'd3)
                    begin
                        hbc_next   = hbc_reg + 2'd1;
                        shift_next = len_shift;
                    end
                    else
                    begin
                        hbc_next   = 2'd0;
                        shift_next = 64'd0;
                        ce_next    = 1'b0;
                        if (total_ok)
                        begin
                            remaining_next = total - LEN_HDR_BYTES;
                            phase_next     = PH_HDR;
                        end
                        else
                        begin
                            remaining_next = 32'd0;
                            phase_next     = PH_LEN;
                        end
                    end
                end
                default:
                begin
                    remaining_next = rem_dec;
                    phase_next     = step_phase;
                    ce_next        = step_ce;
                    if (start_pay)
                    begin
                        pending_next  = start_kind;
                        pay_size_next = start_size;
                        pay_left_next = start_size;
                        shift_next    = 64'd0;
                    end
                    if (phase_reg == PH_PAY)
                    begin
                        pay_left_next = pay_left_dec;
                        shift_next    = pay_done ? 64'd0 : shift_upd;
                    end
                    if (str_load)
                        str_left_next = str_load_val;
                    else if (phase_reg == PH_STR)
                        str_left_next = str_left_dec;
                    if (rem_zero)
                    begin
                        hbc_next   = 2'd0;
                        shift_next = 64'd0;
                        ce_next    = 1'b0;
                        if (raw_hit)
                            phase_next = clean ? PH_PEND_END : PH_PEND_ERR;
                        else
                            phase_next = PH_LEN;
                    end
                end
            endcase
        end
    end

    // token for the accepted byte
    always_comb
    begin
        tok_valid_next = tok_valid_reg && !token_ready;
        kind_next      = kind_reg;
        value_next     = value_reg;
        length_next    = length_reg;
        err_next       = err_reg;
        if (acc)
        begin
            tok_valid_next = 1'b0;
            kind_next      = K_END;
            value_next     = 64'd0;
            length_next    = 32'd0;
            err_next       = E_NONE;
            case (phase_reg)
                PH_PEND_END:
                    tok_valid_next = 1'b1;
                PH_PEND_ERR:
                begin
                    tok_valid_next = 1'b1;
                    kind_next      = K_ERR;
                    err_next       = E_TRUNC;
                end
                PH_LEN:
                    tok_valid_next = (hbc_reg == 2'd3) && !total_ok;
                default:
                begin
                    if (raw_hit)
                    begin
                        tok_valid_next = 1'b1;
                        kind_next      = raw_kind;
                        value_next     = raw_value;
                        length_next    = raw_len;
                        err_next       = raw_err;
                    end
                    else if (rem_zero)
                    begin
                        tok_valid_next = 1'b1;
                        if (!clean)
                        begin
                            kind_next = K_ERR;
                            err_next  = E_TRUNC;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            hbc_reg       <= 2'd0;
            remaining_reg <= 32'd0;
            shift_reg     <= 64'd0;
            pay_left_reg  <= 4'd0;
            pay_size_reg  <= 4'd0;
            str_left_reg  <= 32'd0;
            pending_reg   <= K_NIL;
            ce_reg        <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hbc_reg       <= hbc_next;
            remaining_reg <= remaining_next;
            shift_reg     <= shift_next;
            pay_left_reg  <= pay_left_next;
            pay_size_reg  <= pay_size_next;
            str_left_reg  <= str_left_next;
            pending_reg   <= pending_next;
            ce_reg        <= ce_next;
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        value_reg  <= value_next;
        length_reg <= length_next;
        err_reg    <= err_next;
    end

    assign token_valid = tok_valid_reg;
    assign kind        = kind_reg;
    assign value       = value_reg;
    assign length      = length_reg;
    assign error_code  = err_reg;

`ifndef SYNTH
    a_len_bytes_silent: assert property (@(posedge clk) disable iff (!rst_n)
        acc && phase_reg == PH_LEN && hbc_reg != 2'd3 |=> !tok_valid_reg)
        else $error("token produced by a length header byte");

    a_body_has_length: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_HDR || phase_reg == PH_PAY || phase_reg == PH_STR)
        |-> remaining_reg != 32'd0)
        else $error("inside stream body with no length left");

    a_pay_count: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY |-> pay_left_reg != 4'd0)
        else $error("payload phase with no bytes left");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg |-> ((kind_reg == K_ERR) == (err_reg != E_NONE)))
        else $error("error code does not match token kind");
`endif

endmodule

`default_nettype wire
